[rtl/uoi_pkg.sv]
package uoi_pkg;

  localparam int unsigned FracBitsDefault    = 16;
  localparam int unsigned CordicStepsDefault = 18;
  localparam int unsigned TimeFrac           = 16;

  localparam logic [63:0] InvTwoPiQ64 = 64'h28BE60DB9391054A;
  localparam logic [35:0] TwoPiQ32    = 36'h6487ED511;
  localparam logic [33:0] CordicGain  = 34'h026DD3B6A;

  localparam logic [23:0] OffsetRReset = 24'h010000;

  typedef struct packed {
    logic [31:0]        time_stamp;
    logic signed [23:0] lin_speed;
    logic signed [23:0] turn_rate;
  } uoi_in_t;

  typedef struct packed {
    logic signed [47:0] point_x;
    logic signed [47:0] point_y;
    logic signed [47:0] heading;
  } uoi_out_t;

  // Arctangent table in Q2.30 radians, one entry per rotation.
  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      5'd24: r = 32'h0000003F;
      5'd25: r = 32'h0000001F;
      5'd26: r = 32'h0000000F;
      5'd27: r = 32'h00000008;
      5'd28: r = 32'h00000004;
      5'd29: r = 32'h00000002;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

[rtl/uoi_cordic.sv]
module uoi_cordic #(
  parameter int unsigned CordicSteps = uoi_pkg::CordicStepsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [33:0] angle_i,
  output logic               done_o,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);

  localparam int unsigned CntW = $clog2(CordicSteps + 1);

  logic signed [33:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic signed [33:0] dx, dy, at;

  always_comb begin
    dx = x_q >>> cnt_q;
    dy = y_q >>> cnt_q;
    at = $signed({2'b00, uoi_pkg::atan_q30(5'(cnt_q))});
  end

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d = $signed(uoi_pkg::CordicGain);
      y_d = '0;
      z_d = angle_i;
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_d = x_q - dy;
        y_d = y_q + dx;
        z_d = z_q - at;
      end else begin
        x_d = x_q + dy;
        y_d = y_q - dx;
        z_d = z_q + at;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(CordicSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign done_o = done_q;
  assign cos_o  = x_q;
  assign sin_o  = y_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("cordic done held");
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("cordic done while busy");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("cordic restarted while busy");

endmodule

[rtl/unicycle_odometry_integrator.sv]
// Odometry integrator for a unicycle model with an offset tracking point. Each
// transaction carries a Q16.16 time stamp, a speed and a turn rate; the block
// returns the tracked point and the integrated heading, one result per input.
// The result is offered once the phase, angle, CORDIC, rate, trapezoid and
// offset steps are through, and the next input is taken only after the
// previous result has been taken. The steps use the iterative CORDIC and
// one shared 33x33 multiplier that serves the three phase partial products,
// the angle scaling, the rates, the three trapezoids and the two offset
// products in turn. The input stall stays high from acceptance until the
// result is taken.
module unicycle_odometry_integrator #(
  parameter int unsigned FRAC_BITS    = uoi_pkg::FracBitsDefault,
  parameter int unsigned CORDIC_STEPS = uoi_pkg::CordicStepsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  uoi_pkg::uoi_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output uoi_pkg::uoi_out_t out_data_o,
  input  logic             cfg_we_i,
  input  logic [23:0]      cfg_wdata_i
);

  localparam int unsigned RShift    = 30 - FRAC_BITS;
  localparam int unsigned TrapShift = uoi_pkg::TimeFrac + 1;
  localparam logic [63:0] ScaleC =
    (uoi_pkg::InvTwoPiQ64 + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  localparam logic [31:0] TwoPiLo = uoi_pkg::TwoPiQ32[31:0];
  localparam logic [3:0]  TwoPiHi = uoi_pkg::TwoPiQ32[35:32];
  localparam logic signed [65:0] Max48 = 66'sh7FFFFFFFFFFF;
  localparam logic signed [65:0] Min48 = -Max48 - 66'sd1;

  typedef enum logic [16:0] {
    S_IDLE = 17'b00000000000000001,
    S_PH0  = 17'b00000000000000010,
    S_PH1  = 17'b00000000000000100,
    S_PH2  = 17'b00000000000001000,
    S_PH3  = 17'b00000000000010000,
    S_ANG  = 17'b00000000000100000,
    S_CST  = 17'b00000000001000000,
    S_CORD = 17'b00000000010000000,
    S_XR   = 17'b00000000100000000,
    S_YR   = 17'b00000001000000000,
    S_TX   = 17'b00000010000000000,
    S_TY   = 17'b00000100000000000,
    S_TH   = 17'b00001000000000000,
    S_PX   = 17'b00010000000000000,
    S_PY   = 17'b00100000000000000,
    S_FIN  = 17'b01000000000000000,
    S_OUT  = 17'b10000000000000000
  } state_e;

  state_e state_q, state_d;

  logic [23:0]        offset_r_q;
  logic signed [47:0] sum_x_q, sum_y_q, sum_h_q;
  logic signed [39:0] prev_xr_q, prev_yr_q, xr_q, yr_q;
  logic signed [23:0] prev_w_q;
  logic [31:0]        prev_t_q;
  uoi_pkg::uoi_in_t   item_q;
  logic [31:0]        acc_q;
  logic [31:0]        phase_hi_q;
  logic [31:0]        head_hi;
  logic [27:0]        turn;
  logic [1:0]         quad;
  logic signed [33:0] ang;
  logic signed [33:0] c_q, s_q;
  logic signed [47:0] px_q, py_q;
  logic               adv_q;
  logic [31:0]        dt_q;

  // Shared signed multiplier, registered product.
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod_q;

  logic               cord_start, cord_done;
  logic signed [33:0] cord_c, cord_s;
  logic signed [33:0] c_rnd, s_rnd;

  function automatic logic signed [65:0] rshift(input logic signed [65:0] v,
                                                input int unsigned n);
    logic signed [65:0] r;
    if (n == 0) r = v;
    else r = (v + (66'sd1 <<< (n - 1))) >>> n;
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
    logic signed [47:0] r;
    if (v > Max48) r = 48'(Max48);
    else if (v < Min48) r = 48'(Min48);
    else r = v[47:0];
    return r;
  endfunction

  uoi_cordic #(.CordicSteps(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni,
    .start_i(cord_start), .angle_i(ang),
    .done_o(cord_done), .cos_o(cord_c), .sin_o(cord_s)
  );

  // Phase bits 63:32 hold the quadrant and the quarter-turn fraction.
  assign head_hi = {{16{sum_h_q[47]}}, sum_h_q[47:32]};
  assign turn    = phase_hi_q[29:2];
  assign quad    = phase_hi_q[31:30];
  assign ang     = 34'(prod_q[63:32]) + (34'({6'd0, turn}) * 34'(TwoPiHi));
  assign c_rnd   = 34'(rshift(66'(cord_c), RShift));
  assign s_rnd   = 34'(rshift(66'(cord_s), RShift));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_PH0: begin mul_a = {1'b0, sum_h_q[31:0]}; mul_b = {1'b0, ScaleC[31:0]}; end
      S_PH1: begin mul_a = {1'b0, sum_h_q[31:0]}; mul_b = {1'b0, ScaleC[63:32]}; end
      S_PH2: begin mul_a = {1'b0, head_hi}; mul_b = {1'b0, ScaleC[31:0]}; end
      S_ANG: begin mul_a = {5'd0, turn}; mul_b = {1'b0, TwoPiLo}; end
      S_XR:  begin mul_a = 33'(item_q.lin_speed); mul_b = 33'(c_q); end
      S_YR:  begin mul_a = 33'(item_q.lin_speed); mul_b = 33'(s_q); end
      S_TX:  begin mul_a = 33'(xr_q) + 33'(prev_xr_q); mul_b = {1'b0, dt_q}; end
      S_TY:  begin mul_a = 33'(yr_q) + 33'(prev_yr_q); mul_b = {1'b0, dt_q}; end
      S_TH:  begin
        mul_a = 33'(item_q.turn_rate) + 33'(prev_w_q);
        mul_b = {1'b0, dt_q};
      end
      S_PX:  begin mul_a = {9'd0, offset_r_q}; mul_b = 33'(c_q); end
      S_PY:  begin mul_a = {9'd0, offset_r_q}; mul_b = 33'(s_q); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_PH0;
      S_PH0:  state_d = S_PH1;
      S_PH1:  state_d = S_PH2;
      S_PH2:  state_d = S_PH3;
      S_PH3:  state_d = S_ANG;
      S_ANG:  state_d = S_CST;
      S_CST:  state_d = S_CORD;
      S_CORD: if (cord_done) state_d = S_XR;
      S_XR:   state_d = S_YR;
      S_YR:   state_d = S_TX;
      S_TX:   state_d = S_TY;
      S_TY:   state_d = S_TH;
      S_TH:   state_d = S_PX;
      S_PX:   state_d = S_PY;
      S_PY:   state_d = S_FIN;
      S_FIN:  state_d = S_OUT;
      S_OUT:  if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // The angle product is in prod_q during the start cycle.
  assign cord_start = (state_q == S_CST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      offset_r_q <= uoi_pkg::OffsetRReset;
      sum_x_q    <= '0;
      sum_y_q    <= '0;
      sum_h_q    <= '0;
      prev_xr_q  <= '0;
      prev_yr_q  <= '0;
      prev_w_q   <= '0;
      prev_t_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) offset_r_q <= cfg_wdata_i;
      case (state_q)
        S_TY: if (adv_q) sum_x_q <= sat48(66'(sum_x_q) + rshift(prod_q, TrapShift));
        S_TH: if (adv_q) sum_y_q <= sat48(66'(sum_y_q) + rshift(prod_q, TrapShift));
        S_PX: begin
          if (adv_q) sum_h_q <= sat48(66'(sum_h_q) + rshift(prod_q, TrapShift));
          prev_xr_q <= xr_q;
          prev_yr_q <= yr_q;
          prev_w_q  <= item_q.turn_rate;
          prev_t_q  <= item_q.time_stamp;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (state_q == S_IDLE && in_valid_i) item_q <= in_data_i;
    case (state_q)
      S_PH0: begin
        adv_q <= (item_q.time_stamp > prev_t_q);
        dt_q  <= item_q.time_stamp - prev_t_q;
      end
      S_PH1: acc_q <= prod_q[63:32];
      S_PH2: acc_q <= acc_q + prod_q[31:0];
      S_PH3: phase_hi_q <= acc_q + prod_q[31:0];
      S_CORD: begin
        if (cord_done) begin
          case (quad)
            2'd0: begin c_q <= c_rnd;  s_q <= s_rnd;  end
            2'd1: begin c_q <= -s_rnd; s_q <= c_rnd;  end
            2'd2: begin c_q <= -c_rnd; s_q <= -s_rnd; end
            default: begin c_q <= s_rnd; s_q <= -c_rnd; end
          endcase
        end
      end
      S_YR:  xr_q <= 40'(rshift(prod_q, FRAC_BITS));
      S_TX:  yr_q <= 40'(rshift(prod_q, FRAC_BITS));
      S_PY:  px_q <= sat48(66'(sum_x_q) + rshift(prod_q, FRAC_BITS));
      S_FIN: py_q <= sat48(66'(sum_y_q) + rshift(prod_q, FRAC_BITS));
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = '{point_x: px_q, point_y: py_q, heading: sum_h_q};

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_out_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open while result pending");
  a_out_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_FIN) else $error("result out of order");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");
  a_cord_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cord_done |-> state_q == S_CORD) else $error("cordic done outside wait");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned HoldCycles = 400;

  class odometry_scoreboard;
    logic [23:0] offset;
    longint sum_x, sum_y, sum_head;
    longint last_xrate, last_yrate, last_turn;
    logic [31:0] last_stamp;
    uoi_pkg::uoi_out_t pose_q[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned stalled_stamps;

    function new();
      offset = uoi_pkg::OffsetRReset;
      sum_x = 0;
      sum_y = 0;
      sum_head = 0;
      last_xrate = 0;
      last_yrate = 0;
      last_turn = 0;
      last_stamp = '0;
      mismatches = 0;
      results_seen = 0;
      stalled_stamps = 0;
    endfunction

    function longint round_down(longint v, int unsigned n);
      if (n == 0) return v;
      return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function longint clamp48(longint v);
      if (v > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
      if (v < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
      return v;
    endfunction

    function void cordic(longint theta, output longint cos_v, output longint sin_v);
      longint unsigned scale, phase, turn;
      logic [1:0] quad;
      longint x, y, z, dx, dy, c, s;
      scale = (uoi_pkg::InvTwoPiQ64 + (64'd1 << (uoi_pkg::FracBitsDefault - 1)))
              >> uoi_pkg::FracBitsDefault;
      phase = longint'(theta) * scale;
      quad = phase[63:62];
      turn = (phase & 64'h3FFF_FFFF_FFFF_FFFF) >> 34;
      z = longint'((turn * {28'd0, uoi_pkg::TwoPiQ32}) >> 32);
      x = longint'({30'd0, uoi_pkg::CordicGain});
      y = 0;
      for (int i = 0; i < uoi_pkg::CordicStepsDefault; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - longint'({32'd0, uoi_pkg::atan_q30(i[4:0])});
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + longint'({32'd0, uoi_pkg::atan_q30(i[4:0])});
        end
      end
      c = round_down(x, 30 - uoi_pkg::FracBitsDefault);
      s = round_down(y, 30 - uoi_pkg::FracBitsDefault);
      case (quad)
        2'd0: begin cos_v = c; sin_v = s; end
        2'd1: begin cos_v = -s; sin_v = c; end
        2'd2: begin cos_v = -c; sin_v = -s; end
        default: begin cos_v = s; sin_v = -c; end
      endcase
    endfunction

    // Advances the pose by one transaction and queues the expected result.
    function void note_input(uoi_pkg::uoi_in_t d);
      longint v, w, c, s, xr, yr, dt, off, px, py;
      uoi_pkg::uoi_out_t exp_pose;
      v = d.lin_speed;
      w = d.turn_rate;
      cordic(sum_head, c, s);
      xr = round_down(v * c, uoi_pkg::FracBitsDefault);
      yr = round_down(v * s, uoi_pkg::FracBitsDefault);
      if (d.time_stamp > last_stamp) begin
        dt = longint'({32'd0, d.time_stamp - last_stamp});
        sum_x = clamp48(sum_x + round_down((xr + last_xrate) * dt, uoi_pkg::TimeFrac + 1));
        sum_y = clamp48(sum_y + round_down((yr + last_yrate) * dt, uoi_pkg::TimeFrac + 1));
        sum_head = clamp48(sum_head + round_down((w + last_turn) * dt,
                                                 uoi_pkg::TimeFrac + 1));
      end else begin
        stalled_stamps++;
      end
      last_xrate = xr;
      last_yrate = yr;
      last_turn = w;
      last_stamp = d.time_stamp;
      off = longint'({40'd0, offset});
      px = clamp48(sum_x + round_down(off * c, uoi_pkg::FracBitsDefault));
      py = clamp48(sum_y + round_down(off * s, uoi_pkg::FracBitsDefault));
      exp_pose.point_x = px[47:0];
      exp_pose.point_y = py[47:0];
      exp_pose.heading = sum_head[47:0];
      pose_q.push_back(exp_pose);
    endfunction

    function void check_result(uoi_pkg::uoi_out_t got);
      uoi_pkg::uoi_out_t want;
      results_seen++;
      if (pose_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction %h", got);
        return;
      end
      want = pose_q.pop_front();
      if (got.point_x !== want.point_x || got.point_y !== want.point_y ||
          got.heading !== want.heading) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch on result %0d:", results_seen);
          $display("  x expected %h actual %h", want.point_x, got.point_x);
          $display("  y expected %h actual %h", want.point_y, got.point_y);
          $display("  heading expected %h actual %h", want.heading, got.heading);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  uoi_pkg::uoi_in_t in_data;
  logic out_valid;
  logic out_stall = 1'b0;
  uoi_pkg::uoi_out_t out_data;
  logic cfg_we;
  logic [23:0] cfg_wdata;

  odometry_scoreboard sb;
  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct = 53;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  logic [31:0] stamp;

  unicycle_odometry_integrator dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o(out_data),
    .cfg_we_i(cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    sb = new();
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // The receiver; a requested long hold-off is counted here.
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_pose(input logic [31:0] t, input logic [23:0] v, input logic [23:0] w);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{time_stamp: t, lin_speed: v, turn_rate: w};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pose_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_offset(input logic [23:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.offset = value;
  endtask

  // Mostly small forward steps, with repeated, backward and very large jumps.
  task automatic send_random(input int unsigned count);
    int unsigned pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 78) stamp = stamp + $urandom_range(1, 4000);
      else if (pick < 88) stamp = stamp;
      else if (pick < 94) stamp = stamp - $urandom_range(1, 100000);
      else stamp = $urandom();
      if ($urandom_range(3) == 0)
        send_pose(stamp, 24'($urandom()), 24'($urandom()));
      else
        send_pose(stamp, 24'($signed($urandom_range(0, 400000)) - 200000),
                  24'($signed($urandom_range(0, 400000)) - 200000));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    sender_idle_pct = 34;
    stamp = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a stamp equal to the reset time, field extremes, backward
    // and repeated stamps, the largest jump, and heading wrapping turns.
    send_pose(32'h0, 24'h7FFFFF, 24'h7FFFFF);
    send_pose(32'h1, 24'h7FFFFF, 24'h7FFFFF);
    send_pose(32'h10000, 24'h800000, 24'h800000);
    send_pose(32'h10000, 24'h000000, 24'h000000);
    send_pose(32'h8000, 24'h010000, 24'h020000);
    send_pose(32'hFFFFFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_pose(32'hFFFFFFFF, 24'h800000, 24'h800000);
    send_pose(32'h0, 24'hFFFFFF, 24'hFFFFFF);
    send_pose(32'hFFFFFFFF, 24'h7FFFFF, 24'h7FFFFF);
    for (int k = 0; k < 8; k++) send_pose(32'h1000 * k, 24'h010000, 24'h00C90F + 24'(k * 24'h8000));
    send_pose(32'h80000000, 24'h555555, 24'hAAAAAA);
    send_pose(32'h7FFFFFFF, 24'hAAAAAA, 24'h555555);
    stamp = 32'h7FFFFFFF;
    drain();

    write_offset(24'hFFFFFF);
    hold_requests = hold_requests + 1;
    send_random(220);
    drain();

    write_offset(24'h000000);
    sender_idle_pct = 53;
    receiver_idle_pct = 34;
    send_random(220);
    drain();

    write_offset(24'($urandom()));
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    send_random(210);
    drain();

    $display("Checked %0d results, %0d of them with a stamp that did not advance.",
             sb.results_seen, sb.stalled_stamps);
    $display("Offsets 1.0, max, zero and random; mismatches %0d, results still awaited %0d.",
             sb.mismatches, sb.pose_q.size());
    if (sb.mismatches == 0 && sb.pose_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
